// ----- hw/rtl/rems_pkg.sv -----
// ----------------------------------------------------------------------------
// Rotary encoder menu selector package
// Shared widths, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package rems_pkg;

    localparam int unsigned SEL_OUT_W   = 6;
    localparam int unsigned COUNT_W     = 7;
    localparam int unsigned TICKS_W     = 8;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ITEM_COUNT     = 2'd0,
        CFG_DEBOUNCE_TICKS = 2'd1
    } cfg_reg_t;

    localparam logic [COUNT_W-1:0] ITEM_COUNT_RST     = 7'd2;
    localparam logic [TICKS_W-1:0] DEBOUNCE_TICKS_RST = 8'd10;

endpackage

// ----- hw/rtl/rotary_encoder_menu_selector.sv -----
// ----------------------------------------------------------------------------
// Rotary encoder menu selector
// An accepted sample's result is registered in the output. Throughput
// is one sample per cycle while the output is empty or m_ready is high; the
// selection and debounce state update per sample. Reset is synchronous and
// active low; it restores the default configuration and scanning state.
// ----------------------------------------------------------------------------
module rotary_encoder_menu_selector
    import rems_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_enc_clk,
    input  logic                  s_enc_data,
    input  logic                  s_push_sw,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SEL_OUT_W-1:0]  m_sel_index,
    output logic                  m_moved,
    output logic                  m_confirmed
);

    localparam int unsigned SEL_W = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int unsigned CMP_W = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;
    localparam int unsigned WIDE_W = (SEL_W > SEL_OUT_W) ? SEL_W : SEL_OUT_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ITEMS);

    typedef enum logic [1:0] {
        PH_SCAN     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_RELEASE  = 2'd2
    } phase_t;

    logic [COUNT_W-1:0]   item_count_reg;
    logic [TICKS_W-1:0]   debounce_ticks_reg;
    logic [SEL_W-1:0]     sel_reg, sel_next;
    logic                 prev_clk_reg, prev_clk_next;
    logic                 prev_sw_reg, prev_sw_next;
    logic                 fresh_reg, fresh_next;
    phase_t               phase_reg, phase_next;
    logic [TICKS_W-1:0]   wait_reg, wait_next;
    logic                 out_valid_reg;
    logic [SEL_OUT_W-1:0] out_sel_reg, out_sel_next;
    logic                 out_moved_reg, out_moved_next;
    logic                 out_conf_reg, out_conf_next;

    logic [CMP_W-1:0]     count_raw;
    logic [CMP_W-1:0]     count_eff;
    logic [CMP_W-1:0]     sel_ext;
    logic [CMP_W-1:0]     sel_up;
    logic [CMP_W-1:0]     sel_down;
    logic [WIDE_W-1:0]    shown_wide;
    logic                 accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    assign m_valid     = out_valid_reg;
    assign m_sel_index = out_sel_reg;
    assign m_moved     = out_moved_reg;
    assign m_confirmed = out_conf_reg;

    always_comb begin
        count_raw = CMP_W'(item_count_reg);
        if (count_raw == '0) begin
            count_eff = CMP_W'(1);
        end else if (count_raw > MAX_CMP) begin
            count_eff = MAX_CMP;
        end else begin
            count_eff = count_raw;
        end
        sel_ext = CMP_W'(sel_reg);
        if (sel_ext + CMP_W'(1) >= count_eff) begin
            sel_up = '0;
        end else begin
            sel_up = sel_ext + CMP_W'(1);
        end
        if (sel_ext == '0 || sel_ext >= count_eff) begin
            sel_down = count_eff - CMP_W'(1);
        end else begin
            sel_down = sel_ext - CMP_W'(1);
        end
    end

    always_comb begin
        sel_next       = sel_reg;
        prev_clk_next  = prev_clk_reg;
        prev_sw_next   = prev_sw_reg;
        fresh_next     = fresh_reg;
        phase_next     = phase_reg;
        wait_next      = wait_reg;
        out_moved_next = 1'b0;
        out_conf_next  = 1'b0;
        shown_wide     = WIDE_W'(sel_reg);

        unique case (phase_reg)
            PH_DEBOUNCE: begin
                if (wait_reg < debounce_ticks_reg) begin
                    wait_next = wait_reg + TICKS_W'(1);
                end else if (!s_push_sw) begin
                    phase_next = PH_RELEASE;
                end else begin
                    phase_next   = PH_SCAN;
                    prev_sw_next = 1'b0;
                end
            end
            PH_RELEASE: begin
                if (s_push_sw) begin
                    out_conf_next = 1'b1;
                    sel_next      = '0;
                    fresh_next    = 1'b1;
                    prev_sw_next  = 1'b1;
                    phase_next    = PH_SCAN;
                end
            end
            default: begin
                phase_next = PH_SCAN;
                if (fresh_reg) begin
                    prev_clk_next = s_enc_clk;
                    fresh_next    = 1'b0;
                end else begin
                    if (s_enc_clk && !prev_clk_reg) begin
                        if (!s_enc_data) begin
                            sel_next = sel_up[SEL_W-1:0];
                        end else begin
                            sel_next = sel_down[SEL_W-1:0];
                        end
                        out_moved_next = 1'b1;
                    end
                    prev_clk_next = s_enc_clk;
                    if (prev_sw_reg && !s_push_sw) begin
                        phase_next = PH_DEBOUNCE;
                        wait_next  = '0;
                    end
                    prev_sw_next = s_push_sw;
                    shown_wide   = WIDE_W'(sel_next);
                end
            end
        endcase
        out_sel_next = shown_wide[SEL_OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_count_reg     <= ITEM_COUNT_RST;
            debounce_ticks_reg <= DEBOUNCE_TICKS_RST;
            sel_reg            <= '0;
            prev_clk_reg       <= 1'b0;
            prev_sw_reg        <= 1'b1;
            fresh_reg          <= 1'b1;
            phase_reg          <= PH_SCAN;
            wait_reg           <= '0;
            out_valid_reg      <= 1'b0;
            out_sel_reg        <= '0;
            out_moved_reg      <= 1'b0;
            out_conf_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_ITEM_COUNT:     item_count_reg     <= cfg_data[COUNT_W-1:0];
                    CFG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data[TICKS_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                sel_reg       <= sel_next;
                prev_clk_reg  <= prev_clk_next;
                prev_sw_reg   <= prev_sw_next;
                fresh_reg     <= fresh_next;
                phase_reg     <= phase_next;
                wait_reg      <= wait_next;
                out_valid_reg <= 1'b1;
                out_sel_reg   <= out_sel_next;
                out_moved_reg <= out_moved_next;
                out_conf_reg  <= out_conf_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
